/* src/fsf_pkg.sv */
// ----------------------------------------------------------------------------
// fsf_pkg
// shared constants and types of the information frame stuffing framer
// ----------------------------------------------------------------------------
package fsf_pkg;

  // framing bytes
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ADDR_BYTE = 8'h03;
  localparam logic [7:0] CTRL_EVEN = 8'h00;
  localparam logic [7:0] CTRL_ODD  = 8'h40;
  localparam logic [7:0] DATA_CTRL = 8'h01;

  // length split radix for L2 / L1
  localparam int LENGTH_RADIX = 256;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // one classified payload byte
  typedef struct packed {
    logic       opens;      // first byte of a fragment, header goes first
    logic [7:0] number;
    logic [7:0] len_hi;     // L2
    logic [7:0] len_lo;     // L1
    logic       esc;        // payload byte needs an inserted escape
    logic [7:0] payload;
    logic       last;       // closes the frame
  } cmd_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // byte sequencer steps
  typedef enum logic [11:0] {
    ST_FLAG_OPEN  = 12'b0000_0000_0001,
    ST_ADDR       = 12'b0000_0000_0010,
    ST_CTRL       = 12'b0000_0000_0100,
    ST_BCC1       = 12'b0000_0000_1000,
    ST_DCTRL      = 12'b0000_0001_0000,
    ST_NUM        = 12'b0000_0010_0000,
    ST_L2         = 12'b0000_0100_0000,
    ST_L1         = 12'b0000_1000_0000,
    ST_ESC        = 12'b0001_0000_0000,
    ST_DATA       = 12'b0010_0000_0000,
    ST_BCC2       = 12'b0100_0000_0000,
    ST_FLAG_CLOSE = 12'b1000_0000_0000
  } step_t;

endpackage

/* src/information_frame_stuffing_framer.sv */
// ----------------------------------------------------------------------------
// information_frame_stuffing_framer
// hdlc-style information frame builder with byte stuffing and xor checks
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in_     | input     | in_valid / in_stall   | payload byte, number, length,
//          |           |                      | last byte mark
//  out_    | output    | out_valid / out_stall | framed byte, run last,
//          |           |                      | frame end
//
//  the back sequencer emits one framed byte per cycle while out_stall is low;
//    each item causes 1 framed byte when it is a plain middle byte, 2 when
//    escaped, 9 or 10 when it opens a frame, plus 2 when it closes one
//  the front takes a transfer whenever the two-entry queue has room
//  reset (rst_n low, synchronous) clears the frame flag, queue, sequencer
//    and running check; no clearing pass is needed
//  out_stall holds the output register; the queue lets the input keep
//    taking transfers while the back waits
//
module information_frame_stuffing_framer (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_payload_byte,
  input  logic [7:0] in_fragment_number,
  input  logic [8:0] in_fragment_length,
  input  logic       in_last_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_frame_end
);

  // front to queue
  logic             q_push;
  fsf_pkg::cmd_t    q_push_cmd;
  // queue to back
  logic             q_pop;
  fsf_pkg::cmd_t    q_head;
  fsf_pkg::q_stat_t q_stat;

  // front: classifies each byte (frame opening, escape, length split)
  fsf_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_payload_byte    (in_payload_byte),
    .in_fragment_number (in_fragment_number),
    .in_fragment_length (in_fragment_length),
    .in_last_byte       (in_last_byte),
    .q_stat             (q_stat),
    .q_push             (q_push),
    .q_cmd              (q_push_cmd)
  );

  // short decoupling queue
  fsf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head_cmd (q_head),
    .stat     (q_stat)
  );

  // back: byte sequencer with running check and output register
  fsf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

endmodule

/* src/fsf_front.sv */
// ----------------------------------------------------------------------------
// fsf_front
// accepts payload bytes, tracks frame opening and classifies each byte
// ----------------------------------------------------------------------------
module fsf_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_payload_byte,
  input  logic [7:0]            in_fragment_number,
  input  logic [8:0]            in_fragment_length,
  input  logic                  in_last_byte,
  input  fsf_pkg::q_stat_t      q_stat,
  output logic                  q_push,
  output fsf_pkg::cmd_t         q_cmd
);

  logic inside_frame_r;
  logic inside_frame_nxt;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  always_comb begin
    q_cmd.opens   = !inside_frame_r;
    q_cmd.number  = in_fragment_number;
    q_cmd.len_hi  = 8'(in_fragment_length / fsf_pkg::LENGTH_RADIX);
    q_cmd.len_lo  = 8'(in_fragment_length % fsf_pkg::LENGTH_RADIX);
    q_cmd.esc     = (in_payload_byte == fsf_pkg::FLAG_BYTE) ||
                    (in_payload_byte == fsf_pkg::ESC_BYTE);
    q_cmd.payload = in_payload_byte;
    q_cmd.last    = in_last_byte;
  end

  // frame stays open until the byte marked last
  always_comb begin
    inside_frame_nxt = inside_frame_r;
    if (q_push) begin
      inside_frame_nxt = !in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_frame_r <= 1'b0;
    end else begin
      inside_frame_r <= inside_frame_nxt;
    end
  end

endmodule

/* src/fsf_queue.sv */
// ----------------------------------------------------------------------------
// fsf_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module fsf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fsf_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output fsf_pkg::cmd_t    head_cmd,
  output fsf_pkg::q_stat_t stat
);

  fsf_pkg::cmd_t                   entry_r [fsf_pkg::QUEUE_DEPTH];
  logic [fsf_pkg::QUEUE_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [fsf_pkg::QUEUE_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [fsf_pkg::QUEUE_CW-1:0]    count_r, count_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign stat.full  = (count_r == fsf_pkg::QUEUE_CW'(fsf_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == fsf_pkg::QUEUE_AW'(fsf_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == fsf_pkg::QUEUE_AW'(fsf_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* src/fsf_back.sv */
// ----------------------------------------------------------------------------
// fsf_back
// byte sequencer: header, stuffed payload, bcc2 and closing flag
// ----------------------------------------------------------------------------
module fsf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  fsf_pkg::q_stat_t q_stat,
  input  fsf_pkg::cmd_t    q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_run_last,
  output logic             out_frame_end
);

  logic                  busy_r, busy_nxt;
  fsf_pkg::step_t        step_r, step_nxt;
  fsf_pkg::cmd_t         cmd_r;
  logic [7:0]            chk_r, chk_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_byte_r;
  logic                  out_run_last_r;
  logic                  out_frame_end_r;

  fsf_pkg::cmd_t         cur_cmd;
  fsf_pkg::step_t        cur_step;
  fsf_pkg::step_t        after_step;
  logic                  have;
  logic                  adv;
  logic                  emit;
  logic                  final_step;
  logic [7:0]            ctrl_byte;
  logic [7:0]            emit_byte;

  assign have    = busy_r || !q_stat.empty;
  assign adv     = !out_valid_r || !out_stall;
  assign emit    = adv && have;
  assign cur_cmd = busy_r ? cmd_r : q_head;
  assign q_pop   = emit && !busy_r;

  assign ctrl_byte = cur_cmd.number[0] ? fsf_pkg::CTRL_ODD : fsf_pkg::CTRL_EVEN;

  // step of the current item: the held step while busy, else the entry step of a fresh item
  always_comb begin
    if (busy_r) begin
      cur_step = step_r;
    end else if (q_head.opens) begin
      cur_step = fsf_pkg::ST_FLAG_OPEN;
    end else if (q_head.esc) begin
      cur_step = fsf_pkg::ST_ESC;
    end else begin
      cur_step = fsf_pkg::ST_DATA;
    end
  end

  always_comb begin
    emit_byte  = fsf_pkg::FLAG_BYTE;
    after_step = fsf_pkg::ST_FLAG_OPEN;
    final_step = 1'b0;
    chk_nxt    = chk_r;
    case (cur_step)
      fsf_pkg::ST_FLAG_OPEN: begin
        emit_byte  = fsf_pkg::FLAG_BYTE;
        after_step = fsf_pkg::ST_ADDR;
      end
      fsf_pkg::ST_ADDR: begin
        emit_byte  = fsf_pkg::ADDR_BYTE;
        after_step = fsf_pkg::ST_CTRL;
      end
      fsf_pkg::ST_CTRL: begin
        emit_byte  = ctrl_byte;
        after_step = fsf_pkg::ST_BCC1;
      end
      fsf_pkg::ST_BCC1: begin
        emit_byte  = fsf_pkg::ADDR_BYTE ^ ctrl_byte;
        after_step = fsf_pkg::ST_DCTRL;
      end
      fsf_pkg::ST_DCTRL: begin
        emit_byte  = fsf_pkg::DATA_CTRL;
        after_step = fsf_pkg::ST_NUM;
        chk_nxt    = fsf_pkg::DATA_CTRL;  // check restarts with the packet
      end
      fsf_pkg::ST_NUM: begin
        emit_byte  = cur_cmd.number;
        after_step = fsf_pkg::ST_L2;
        chk_nxt    = chk_r ^ cur_cmd.number;
      end
      fsf_pkg::ST_L2: begin
        emit_byte  = cur_cmd.len_hi;
        after_step = fsf_pkg::ST_L1;
        chk_nxt    = chk_r ^ cur_cmd.len_hi;
      end
      fsf_pkg::ST_L1: begin
        emit_byte  = cur_cmd.len_lo;
        after_step = cur_cmd.esc ? fsf_pkg::ST_ESC : fsf_pkg::ST_DATA;
        chk_nxt    = chk_r ^ cur_cmd.len_lo;
      end
      fsf_pkg::ST_ESC: begin
        emit_byte  = fsf_pkg::ESC_BYTE;
        after_step = fsf_pkg::ST_DATA;
        chk_nxt    = chk_r ^ fsf_pkg::ESC_BYTE;
      end
      fsf_pkg::ST_DATA: begin
        emit_byte  = cur_cmd.payload;
        after_step = fsf_pkg::ST_BCC2;
        final_step = !cur_cmd.last;
        chk_nxt    = chk_r ^ cur_cmd.payload;
      end
      fsf_pkg::ST_BCC2: begin
        emit_byte  = chk_r;
        after_step = fsf_pkg::ST_FLAG_CLOSE;
        chk_nxt    = '0;
      end
      fsf_pkg::ST_FLAG_CLOSE: begin
        emit_byte  = fsf_pkg::FLAG_BYTE;
        after_step = fsf_pkg::ST_FLAG_OPEN;
        final_step = 1'b1;
      end
      default: begin
        emit_byte  = fsf_pkg::FLAG_BYTE;
        after_step = fsf_pkg::ST_FLAG_OPEN;
        final_step = 1'b1;
      end
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = have;
    end
    if (emit) begin
      busy_nxt = !final_step;
      step_nxt = after_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= fsf_pkg::ST_FLAG_OPEN;
      chk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (emit) begin
        chk_r <= chk_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_head;
    end
    if (emit) begin
      out_byte_r      <= emit_byte;
      out_run_last_r  <= final_step;
      out_frame_end_r <= (cur_step == fsf_pkg::ST_FLAG_CLOSE);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_run_last  = out_run_last_r;
  assign out_frame_end = out_frame_end_r;

endmodule
